// ===== rtl/pos_pkg.sv =====
// ----------------------------------------------------------------------------
// pos_pkg: shared types and constants of the periodic output scheduler
// Register layout, opcodes, force codes and status types used by the top
// level and by the bit-serial remainder unit.
// ----------------------------------------------------------------------------
package pos_pkg;

   localparam int CHANNELS_DEF  = 4;
   localparam int TIME_BITS_DEF = 20;

   localparam int SLOT_COUNT    = 4;
   localparam int SLOT_BITS     = 2;
   localparam int SEC_BITS      = 32;
   localparam int REMAIN_BITS   = 16;
   localparam logic [REMAIN_BITS-1:0] REMAIN_MAX = 16'hFFFF;

   localparam int REG_BITS      = 63;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_IDX_LSB   = 3;

   localparam int EN_BIT        = 0;
   localparam int PIN_LSB       = 1;
   localparam int PIN_BITS      = 2;
   localparam int IVL_LSB       = 3;
   localparam int DUR_LSB       = 23;
   localparam int PHS_LSB       = 43;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_FORCE = 2'd1;
   localparam logic [1:0] OP_EVAL  = 2'd2;

   localparam logic [1:0] MODE_AUTO = 2'd0;
   localparam logic [1:0] MODE_ON   = 2'd1;
   localparam logic [1:0] MODE_OFF  = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== rtl/pos_bit_rem.sv =====
// ----------------------------------------------------------------------------
// pos_bit_rem: bit-serial remainder unit
// Shifts the dividend in one bit per cycle, most significant first, and
// keeps a restoring remainder against the divisor. The divisor must be
// non-zero and held stable while the unit is busy.
// ----------------------------------------------------------------------------
module pos_bit_rem #(
   parameter int DIVIDEND_BITS = pos_pkg::SEC_BITS,
   parameter int DIVISOR_BITS  = pos_pkg::TIME_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output pos_pkg::div_stat_type    stat,
   output logic [DIVISOR_BITS-1:0]  remainder
);

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic [DIVIDEND_BITS-1:0] shift_ff;
   logic [DIVISOR_BITS-1:0]  rem_ff;
   logic [DIVISOR_BITS-1:0]  rem_in;
   logic [DIVISOR_BITS:0]    trial;
   logic [CNT_BITS-1:0]      cnt_ff;
   logic                     busy_ff;
   logic                     done_ff;

   always_comb begin
      trial = {rem_ff, shift_ff[DIVIDEND_BITS-1]};
      if (trial >= {1'b0, divisor}) begin
         rem_in = DIVISOR_BITS'(trial - {1'b0, divisor});
      end else begin
         rem_in = trial[DIVISOR_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_BITS'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(DIVIDEND_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff <= dividend;
         rem_ff   <= '0;
      end else if (busy_ff) begin
         shift_ff <= shift_ff << 1;
         rem_ff   <= rem_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/periodic_output_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_output_scheduler: four-channel cyclic on/off timer
// Keeps a seconds counter and a force mode per channel, evaluates each
// channel's on state and time to next change, and drives the routed pins.
// ----------------------------------------------------------------------------
// A force write or unused opcode goes straight to the report step, which
// raises its item. An evaluation walks the channels in turn: a disabled,
// forced or badly timed channel is settled in the channel step; an auto channel
// runs the bit-serial remainder of seconds and phase, then position and finish;
// the pins are then registered and the item reported. One item at a time: the
// next is taken once the result is raised; a stalled result holds the input off.
// Reset clears the seconds counter, force modes, outputs and setup registers.
module periodic_output_scheduler #(
   parameter int CHANNELS  = pos_pkg::CHANNELS_DEF,
   parameter int TIME_BITS = pos_pkg::TIME_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_opcode,
   input  logic [1:0]                           req_channel,
   input  logic [1:0]                           req_force_mode,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [pos_pkg::SLOT_COUNT-1:0]       rsp_pin_levels,
   output logic [pos_pkg::SLOT_COUNT-1:0]       rsp_channel_on_bits,
   output logic [pos_pkg::SLOT_COUNT-1:0]       rsp_channel_enabled_bits,
   output logic [pos_pkg::SLOT_COUNT-1:0]       rsp_channel_forced_bits,
   output logic [pos_pkg::REMAIN_BITS-1:0]      rsp_remain_0,
   output logic [pos_pkg::REMAIN_BITS-1:0]      rsp_remain_1,
   output logic [pos_pkg::REMAIN_BITS-1:0]      rsp_remain_2,
   output logic [pos_pkg::REMAIN_BITS-1:0]      rsp_remain_3,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pos_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [pos_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [pos_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   localparam int SLOTS    = pos_pkg::SLOT_COUNT;
   localparam int SBITS    = pos_pkg::SLOT_BITS;
   localparam int RBITS    = pos_pkg::REMAIN_BITS;
   localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SAT_BITS = (TIME_BITS > RBITS) ? TIME_BITS : RBITS;
   localparam logic [SLOTS-1:0] CH_MASK = SLOTS'((1 << CHANNELS) - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHAN,
      ST_DIVIDE,
      ST_POSN,
      ST_FINISH,
      ST_PINS,
      ST_REPORT
   } state_type;

   state_type state_ff;

   logic [pos_pkg::REG_BITS-1:0]  setup_ff [SLOTS];
   logic [pos_pkg::SEC_BITS-1:0]  sec_ff;
   logic [1:0]                    force_ff [SLOTS];
   logic [SLOTS-1:0]              on_ff;
   logic [SLOTS-1:0]              pin_ff;
   logic [RBITS-1:0]              remain_ff [SLOTS];
   logic [IDX_BITS-1:0]           idx_ff;
   logic [TIME_BITS-1:0]          pos_ff;
   logic [TIME_BITS-1:0]          pos_in;

   logic                          rsp_valid_ff;
   logic [SLOTS-1:0]              rsp_pins_ff;
   logic [SLOTS-1:0]              rsp_ons_ff;
   logic [SLOTS-1:0]              rsp_ens_ff;
   logic [SLOTS-1:0]              rsp_frc_ff;
   logic [RBITS-1:0]              rsp_remain_ff [SLOTS];

   logic                          req_take;
   logic                          csr_write;
   logic [SBITS-1:0]              cur_slot;
   logic [pos_pkg::REG_BITS-1:0]  cur_setup;
   logic                          cur_en;
   logic [1:0]                    cur_force;
   logic [TIME_BITS-1:0]          cur_ivl;
   logic [TIME_BITS-1:0]          cur_dur;
   logic [TIME_BITS-1:0]          cur_phs;
   logic                          timing_bad;
   logic                          div_start;
   logic                          last_chan;
   pos_pkg::div_stat_type         sec_stat;
   pos_pkg::div_stat_type         phs_stat;
   logic [TIME_BITS-1:0]          sec_rem;
   logic [TIME_BITS-1:0]          phs_rem;
   logic [TIME_BITS:0]            pos_diff;
   logic                          fin_on;
   logic [TIME_BITS-1:0]          fin_span;
   logic [SAT_BITS-1:0]           fin_span_ext;
   logic [RBITS-1:0]              fin_remain;
   logic [SLOTS-1:0]              want_pins;
   logic [SLOTS-1:0]              rep_ens;
   logic [SLOTS-1:0]              rep_frc;
   logic                          rsp_free;

   // ---- configuration port ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = pos_pkg::CSR_DATA_BITS'(
      setup_ff[csr_paddr[pos_pkg::CSR_ADDR_BITS-1:pos_pkg::CSR_IDX_LSB]]);

   // ---- current channel fields ----
   assign cur_slot   = SBITS'(idx_ff);
   assign cur_setup  = setup_ff[cur_slot];
   assign cur_en     = cur_setup[pos_pkg::EN_BIT];
   assign cur_force  = force_ff[cur_slot];
   assign cur_ivl    = cur_setup[pos_pkg::IVL_LSB +: TIME_BITS];
   assign cur_dur    = cur_setup[pos_pkg::DUR_LSB +: TIME_BITS];
   assign cur_phs    = cur_setup[pos_pkg::PHS_LSB +: TIME_BITS];
   assign timing_bad = (cur_ivl == '0) || (cur_dur == '0) || (cur_dur > cur_ivl);
   assign last_chan  = (idx_ff == IDX_BITS'(CHANNELS - 1));
   assign div_start  = (state_ff == ST_CHAN) && cur_en &&
                       (cur_force == pos_pkg::MODE_AUTO) && !timing_bad;

   pos_bit_rem #(
      .DIVIDEND_BITS (pos_pkg::SEC_BITS),
      .DIVISOR_BITS  (TIME_BITS)
   ) u_sec_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (sec_ff),
      .divisor   (cur_ivl),
      .stat      (sec_stat),
      .remainder (sec_rem)
   );

   pos_bit_rem #(
      .DIVIDEND_BITS (pos_pkg::SEC_BITS),
      .DIVISOR_BITS  (TIME_BITS)
   ) u_phs_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (pos_pkg::SEC_BITS'(cur_phs)),
      .divisor   (cur_ivl),
      .stat      (phs_stat),
      .remainder (phs_rem)
   );

   // position = (seconds mod interval - phase mod interval) wrapped into interval
   always_comb begin
      pos_diff = {1'b0, sec_rem} - {1'b0, phs_rem};
      if (sec_rem >= phs_rem) begin
         pos_in = pos_diff[TIME_BITS-1:0];
      end else begin
         pos_in = TIME_BITS'(pos_diff + {1'b0, cur_ivl});
      end
   end

   always_comb begin
      fin_on       = (pos_ff < cur_dur);
      fin_span     = fin_on ? (cur_dur - pos_ff) : (cur_ivl - pos_ff);
      fin_span_ext = SAT_BITS'(fin_span);
      if (fin_span_ext > SAT_BITS'(pos_pkg::REMAIN_MAX)) begin
         fin_remain = pos_pkg::REMAIN_MAX;
      end else begin
         fin_remain = fin_span_ext[RBITS-1:0];
      end
   end

   // route every on channel to its pin; pins beyond the channel count stay low
   always_comb begin
      want_pins = '0;
      rep_ens   = '0;
      rep_frc   = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (on_ff[i]) begin
            want_pins[setup_ff[i][pos_pkg::PIN_LSB +: pos_pkg::PIN_BITS]] = 1'b1;
         end
         rep_ens[i] = setup_ff[i][pos_pkg::EN_BIT];
         rep_frc[i] = (force_ff[i] != pos_pkg::MODE_AUTO);
      end
      want_pins = want_pins & CH_MASK;
      rep_ens   = rep_ens & CH_MASK;
      rep_frc   = rep_frc & CH_MASK;
   end

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         sec_ff       <= '0;
         on_ff        <= '0;
         pin_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_pins_ff  <= '0;
         rsp_ons_ff   <= '0;
         rsp_ens_ff   <= '0;
         rsp_frc_ff   <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            force_ff[i]      <= pos_pkg::MODE_AUTO;
            remain_ff[i]     <= '0;
            setup_ff[i]      <= '0;
            rsp_remain_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            setup_ff[csr_paddr[pos_pkg::CSR_ADDR_BITS-1:pos_pkg::CSR_IDX_LSB]] <=
               csr_pwdata[pos_pkg::REG_BITS-1:0];
         end
         if ((state_ff == ST_REPORT) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (req_take) begin
                  case (req_opcode)
                     pos_pkg::OP_TICK: begin
                        sec_ff   <= sec_ff + pos_pkg::SEC_BITS'(1);
                        state_ff <= ST_CHAN;
                     end
                     pos_pkg::OP_FORCE: begin
                        if ((32'(req_channel) < CHANNELS) &&
                            (req_force_mode <= pos_pkg::MODE_OFF)) begin
                           force_ff[req_channel] <= req_force_mode;
                        end
                        state_ff <= ST_REPORT;
                     end
                     pos_pkg::OP_EVAL: begin
                        state_ff <= ST_CHAN;
                     end
                     default: begin
                        state_ff <= ST_REPORT;
                     end
                  endcase
               end
            end

            ST_CHAN: begin
               if (div_start) begin
                  state_ff <= ST_DIVIDE;
               end else begin
                  // disabled, forced or badly timed: settle the channel now
                  if (!cur_en) begin
                     force_ff[cur_slot] <= pos_pkg::MODE_AUTO;
                  end
                  on_ff[cur_slot]     <= cur_en && (cur_force == pos_pkg::MODE_ON);
                  remain_ff[cur_slot] <= '0;
                  if (last_chan) begin
                     state_ff <= ST_PINS;
                  end else begin
                     idx_ff <= idx_ff + IDX_BITS'(1);
                  end
               end
            end

            ST_DIVIDE: begin
               if (sec_stat.done) begin
                  state_ff <= ST_POSN;
               end
            end

            ST_POSN: begin
               pos_ff   <= pos_in;
               state_ff <= ST_FINISH;
            end

            ST_FINISH: begin
               on_ff[cur_slot]     <= fin_on;
               remain_ff[cur_slot] <= fin_remain;
               if (last_chan) begin
                  state_ff <= ST_PINS;
               end else begin
                  idx_ff   <= idx_ff + IDX_BITS'(1);
                  state_ff <= ST_CHAN;
               end
            end

            ST_PINS: begin
               pin_ff   <= want_pins;
               state_ff <= ST_REPORT;
            end

            ST_REPORT: begin
               // hold until the output register is free
               if (rsp_free) begin
                  rsp_pins_ff <= pin_ff & CH_MASK;
                  rsp_ons_ff  <= on_ff & CH_MASK;
                  rsp_ens_ff  <= rep_ens;
                  rsp_frc_ff  <= rep_frc;
                  for (int i = 0; i < SLOTS; i++) begin
                     rsp_remain_ff[i] <= (i < CHANNELS) ? remain_ff[i] : '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_pin_levels           = rsp_pins_ff;
   assign rsp_channel_on_bits      = rsp_ons_ff;
   assign rsp_channel_enabled_bits = rsp_ens_ff;
   assign rsp_channel_forced_bits  = rsp_frc_ff;
   assign rsp_remain_0             = rsp_remain_ff[0];
   assign rsp_remain_1             = rsp_remain_ff[1];
   assign rsp_remain_2             = rsp_remain_ff[2];
   assign rsp_remain_3             = rsp_remain_ff[3];

   // ---- assertions ----
   a_units_lockstep: assert property (@(posedge clock) disable iff (reset)
      sec_stat == phs_stat)
      else $error("remainder units out of step");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      sec_stat.done |-> (state_ff == ST_DIVIDE))
      else $error("remainder finished outside the divide step");

   a_divide_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (sec_stat.busy || sec_stat.done))
      else $error("divide step waiting on an idle unit");

   a_rsp_from_report: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_REPORT))
      else $error("result raised outside the report step");

   a_unused_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (((rsp_ons_ff | rsp_pins_ff | rsp_frc_ff) & ~CH_MASK) == '0))
      else $error("unused channel reported active");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the periodic output scheduler
// Drives tick, force and evaluate commands under random idling on both
// the request and response sides and compares every status item against a
// cycle-free model of the timer channels, with setups rewritten between
// phases over the configuration port.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [1:0] OP_SPARE  = 2'd3;
   localparam logic [1:0] MODE_RSVD = 2'd3;
   localparam int         NCHAN     = pos_pkg::CHANNELS_DEF;
   localparam logic [63:0] FIELD_MASK =
      64'hFFFFF & ((64'd1 << pos_pkg::TIME_BITS_DEF) - 64'd1);

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] ch;
      logic [1:0] fm;
   } cmd_type;

   typedef struct packed {
      logic [3:0]  pins;
      logic [3:0]  on;
      logic [3:0]  en;
      logic [3:0]  forced;
      logic [15:0] r0;
      logic [15:0] r1;
      logic [15:0] r2;
      logic [15:0] r3;
   } status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode     = 2'd0;
   logic [1:0]  req_channel    = 2'd0;
   logic [1:0]  req_force_mode = 2'd0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [3:0]  rsp_pin_levels;
   logic [3:0]  rsp_channel_on_bits;
   logic [3:0]  rsp_channel_enabled_bits;
   logic [3:0]  rsp_channel_forced_bits;
   logic [15:0] rsp_remain_0;
   logic [15:0] rsp_remain_1;
   logic [15:0] rsp_remain_2;
   logic [15:0] rsp_remain_3;
   logic                              csr_psel    = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite  = 1'b0;
   logic [pos_pkg::CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [pos_pkg::CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [pos_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   periodic_output_scheduler DUT (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_opcode               (req_opcode),
      .req_channel              (req_channel),
      .req_force_mode           (req_force_mode),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_pin_levels           (rsp_pin_levels),
      .rsp_channel_on_bits      (rsp_channel_on_bits),
      .rsp_channel_enabled_bits (rsp_channel_enabled_bits),
      .rsp_channel_forced_bits  (rsp_channel_forced_bits),
      .rsp_remain_0             (rsp_remain_0),
      .rsp_remain_1             (rsp_remain_1),
      .rsp_remain_2             (rsp_remain_2),
      .rsp_remain_3             (rsp_remain_3),
      .csr_psel                 (csr_psel),
      .csr_penable              (csr_penable),
      .csr_pwrite               (csr_pwrite),
      .csr_paddr                (csr_paddr),
      .csr_pwdata               (csr_pwdata),
      .csr_prdata               (csr_prdata),
      .csr_pready               (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // timer model state
   logic [62:0] setup_regs [pos_pkg::SLOT_COUNT];
   logic [31:0] secs;
   logic [1:0]  fmode      [pos_pkg::SLOT_COUNT];
   logic [3:0]  chan_on;
   logic [15:0] remain     [pos_pkg::SLOT_COUNT];
   logic [3:0]  pins;

   cmd_type    cmd_backlog [$];
   status_type status_due  [$];
   cmd_type    cur_cmd;
   cmd_type    next_cmd;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int          errors        = 0;
   int          hold_left     = 0;
   logic        hold_req      = 1'b0;
   logic        hold_ack      = 1'b0;

   function automatic logic [15:0] sat16(input logic [63:0] v);
      return (v > 64'hFFFF) ? pos_pkg::REMAIN_MAX : v[15:0];
   endfunction

   function automatic void eval_channels();
      logic [3:0]  want;
      logic [63:0] r, ivl, dur, phs, pos;
      logic [1:0]  pin;
      logic        on;
      logic [15:0] rem;
      want = '0;
      for (int i = 0; i < NCHAN; i++) begin
         r   = {1'b0, setup_regs[i]};
         pin = r[pos_pkg::PIN_LSB +: pos_pkg::PIN_BITS];
         on  = 1'b0;
         rem = '0;
         if (!r[pos_pkg::EN_BIT]) begin
            fmode[i] = pos_pkg::MODE_AUTO;
         end else if (fmode[i] == pos_pkg::MODE_ON) begin
            on = 1'b1;
         end else if (fmode[i] == pos_pkg::MODE_OFF) begin
            on = 1'b0;
         end else begin
            ivl = (r >> pos_pkg::IVL_LSB) & FIELD_MASK;
            dur = (r >> pos_pkg::DUR_LSB) & FIELD_MASK;
            phs = (r >> pos_pkg::PHS_LSB) & FIELD_MASK;
            if (ivl != 0 && dur != 0 && dur <= ivl) begin
               phs = phs % ivl;
               // exact 64-bit sum, no wrap of the seconds count
               pos = ({32'd0, secs} + ivl - phs) % ivl;
               if (pos < dur) begin
                  on  = 1'b1;
                  rem = sat16(dur - pos);
               end else begin
                  rem = sat16(ivl - pos);
               end
            end
         end
         if (on && pin < NCHAN) want[pin] = 1'b1;
         chan_on[i] = on;
         remain[i]  = rem;
      end
      pins = want;
   endfunction

   function automatic status_type apply_cmd(input cmd_type c);
      status_type s;
      case (c.op)
         pos_pkg::OP_TICK: begin
            secs = secs + 32'd1;
            eval_channels();
         end
         pos_pkg::OP_FORCE: begin
            if (c.ch < NCHAN && c.fm != MODE_RSVD) fmode[c.ch] = c.fm;
         end
         pos_pkg::OP_EVAL: eval_channels();
         default: ;
      endcase
      s.pins = pins;
      s.on   = chan_on;
      for (int i = 0; i < pos_pkg::SLOT_COUNT; i++) begin
         s.en[i]     = (i < NCHAN) && setup_regs[i][pos_pkg::EN_BIT];
         s.forced[i] = (i < NCHAN) && (fmode[i] != pos_pkg::MODE_AUTO);
      end
      s.r0 = remain[0];
      s.r1 = remain[1];
      s.r2 = remain[2];
      s.r3 = remain[3];
      return s;
   endfunction

   // sender: hold the item while stalled, else load the next or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) status_due.push_back(apply_cmd(cur_cmd));
         if (!req_valid || !req_stall) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_cmd = cmd_backlog.pop_front();
               cur_cmd  = next_cmd;
               req_valid      <= 1'b1;
               req_opcode     <= next_cmd.op;
               req_channel    <= next_cmd.ch;
               req_force_mode <= next_cmd.fm;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stall, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_ack != hold_req) begin
         hold_ack  <= hold_req;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         errors++;
         if (errors <= 60)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_due.size() == 0) begin
            errors++;
            if (errors <= 60)
               $display("%0t: unexpected item, expected none, actual pins %0h", $time,
                        rsp_pin_levels);
         end else begin
            want = status_due.pop_front();
            check_field("pin_levels",   want.pins,   rsp_pin_levels);
            check_field("channel_on",   want.on,     rsp_channel_on_bits);
            check_field("enabled",      want.en,     rsp_channel_enabled_bits);
            check_field("forced",       want.forced, rsp_channel_forced_bits);
            check_field("remain_0",     want.r0,     rsp_remain_0);
            check_field("remain_1",     want.r1,     rsp_remain_1);
            check_field("remain_2",     want.r2,     rsp_remain_2);
            check_field("remain_3",     want.r3,     rsp_remain_3);
         end
      end
   end

   function automatic logic [62:0] setup_word(input logic en, input logic [1:0] pin,
                                              input logic [19:0] ivl,
                                              input logic [19:0] dur,
                                              input logic [19:0] phs);
      return {phs, dur, ivl, pin, en};
   endfunction

   function automatic logic [62:0] rand_setup();
      int unsigned k, m, ivl, dur, phs;
      k = $urandom_range(99);
      if (k < 8) return 63'({$urandom, $urandom});
      if (k < 20) begin
         // long interval: remain can saturate
         ivl = $urandom_range(20'hFFFFF, 70000);
         dur = $urandom_range(ivl, 1);
      end else begin
         ivl = $urandom_range(24, 1);
         m   = $urandom_range(9);
         if (m == 0)      dur = 0;
         else if (m == 1) dur = ivl + 1 + $urandom_range(3);
         else             dur = $urandom_range(ivl, 1);
      end
      if ($urandom_range(3) == 0) phs = $urandom_range(20'hFFFFF);
      else                        phs = $urandom_range(2 * ivl) & 20'hFFFFF;
      return setup_word($urandom_range(9) != 0, 2'($urandom_range(3)),
                        20'(ivl), 20'(dur), 20'(phs));
   endfunction

   function automatic cmd_type rand_cmd();
      cmd_type c;
      int unsigned k;
      k    = $urandom_range(99);
      c.ch = 2'($urandom_range(3));
      c.fm = 2'($urandom_range(3));
      if (k < 70)      c.op = pos_pkg::OP_TICK;
      else if (k < 80) c.op = pos_pkg::OP_EVAL;
      else if (k < 95) c.op = pos_pkg::OP_FORCE;
      else             c.op = OP_SPARE;
      return c;
   endfunction

   task automatic csr_write(input int idx, input logic [62:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= pos_pkg::CSR_ADDR_BITS'(idx << pos_pkg::CSR_IDX_LSB);
      csr_pwdata  <= {1'b0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      setup_regs[idx] = val;
   endtask

   task automatic drain();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || req_valid || status_due.size() != 0);
   endtask

   task automatic push(input logic [1:0] op, input logic [1:0] ch, input logic [1:0] fm);
      cmd_backlog.push_back('{op: op, ch: ch, fm: fm});
   endtask

   initial begin
      secs    = '0;
      chan_on = '0;
      pins    = '0;
      for (int i = 0; i < pos_pkg::SLOT_COUNT; i++) begin
         setup_regs[i] = '0;
         fmode[i]      = pos_pkg::MODE_AUTO;
         remain[i]     = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 6;
      recv_idle_pct = 77;

      // phase offset past the interval, shared pin, on time above interval,
      // all-ones setup, saturating remain
      csr_write(0, setup_word(1'b1, 2'd0, 20'd5, 20'd2, 20'd7));
      csr_write(1, setup_word(1'b1, 2'd0, 20'd3, 20'd4, 20'd0));
      csr_write(2, {63{1'b1}});
      csr_write(3, setup_word(1'b1, 2'd2, 20'hFFFFF, 20'd1, 20'd0));
      push(pos_pkg::OP_EVAL,  2'd0, 2'd0);
      push(pos_pkg::OP_TICK,  2'd3, 2'd3);
      push(pos_pkg::OP_TICK,  2'd0, 2'd0);
      push(OP_SPARE,          2'd3, 2'd3);
      push(pos_pkg::OP_FORCE, 2'd0, pos_pkg::MODE_ON);
      push(pos_pkg::OP_TICK,  2'd0, 2'd0);
      push(pos_pkg::OP_FORCE, 2'd1, pos_pkg::MODE_OFF);
      push(pos_pkg::OP_FORCE, 2'd2, MODE_RSVD);
      push(pos_pkg::OP_TICK,  2'd0, 2'd0);
      push(pos_pkg::OP_FORCE, 2'd3, pos_pkg::MODE_ON);
      push(pos_pkg::OP_EVAL,  2'd0, 2'd0);
      push(pos_pkg::OP_FORCE, 2'd0, pos_pkg::MODE_AUTO);
      push(pos_pkg::OP_TICK,  2'd0, 2'd0);
      push(pos_pkg::OP_TICK,  2'd0, 2'd0);
      drain();

      // disabled channel keeps its force until evaluated; zero timing fields
      csr_write(0, '0);
      csr_write(1, setup_word(1'b1, 2'd1, 20'd4, 20'd0, 20'd1));
      csr_write(2, setup_word(1'b1, 2'd3, 20'd0, 20'd1, 20'd0));
      csr_write(3, setup_word(1'b1, 2'd1, 20'd1, 20'd1, 20'hFFFFF));
      push(pos_pkg::OP_FORCE, 2'd0, pos_pkg::MODE_ON);
      push(pos_pkg::OP_FORCE, 2'd3, pos_pkg::MODE_AUTO);
      push(pos_pkg::OP_TICK,  2'd0, 2'd0);
      push(pos_pkg::OP_FORCE, 2'd1, pos_pkg::MODE_AUTO);
      push(pos_pkg::OP_EVAL,  2'd0, 2'd0);
      push(pos_pkg::OP_TICK,  2'd0, 2'd0);
      push(pos_pkg::OP_TICK,  2'd0, 2'd0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         if (ph < 3) begin
            send_idle_pct = 6;
            recv_idle_pct = 77;
         end else if (ph < 6) begin
            send_idle_pct = 77;
            recv_idle_pct = 6;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int i = 0; i < pos_pkg::SLOT_COUNT; i++) csr_write(i, rand_setup());
         for (int n = 0; n < 125; n++) cmd_backlog.push_back(rand_cmd());
         // block fills while the receiver holds off
         if (ph == 6) hold_req = ~hold_req;
         drain();
      end

      repeat (200) @(posedge clock);
      if (status_due.size() != 0) errors++;
      if (errors == 0) begin
         $display("[periodic_output_scheduler] OK");
      end else begin
         $display("[periodic_output_scheduler] ERROR");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("[periodic_output_scheduler] ERROR");
      $finish;
   end

endmodule
